// ===== src/sbhc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sensor baseline / hysteresis controller.
// Holds register reset values, field widths and register indexes; no dependencies.
package sbhc_pkg;

    // Default group length for averaging
    localparam int AVG_COUNT_DEF = 10;

    // Field and accumulator widths
    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 16;
    localparam int PCT_W    = 8;
    localparam int PM_W     = 11;
    localparam int TICK_W   = 8;

    // Threshold comparison widths (percent path, per-mille path)
    localparam int PCT_CMP_W = 24;
    localparam int PM_CMP_W  = 27;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TOUCH_RELEASE = 3'd0,
        REG_TOUCH_PRESS   = 3'd1,
        REG_LIGHT_LOW     = 3'd2,
        REG_LIGHT_HIGH    = 3'd3,
        REG_TEMP_LOW      = 3'd4,
        REG_TEMP_HIGH     = 3'd5,
        REG_TIMEOUT       = 3'd6
    } reg_idx_t;

    // Register reset values
    localparam logic [PCT_W-1:0]  TOUCH_RELEASE_RST = 8'd90;
    localparam logic [PCT_W-1:0]  TOUCH_PRESS_RST   = 8'd80;
    localparam logic [PCT_W-1:0]  LIGHT_LOW_RST     = 8'd110;
    localparam logic [PCT_W-1:0]  LIGHT_HIGH_RST    = 8'd130;
    localparam logic [PM_W-1:0]   TEMP_LOW_RST      = 11'd1010;
    localparam logic [PM_W-1:0]   TEMP_HIGH_RST     = 11'd1030;
    localparam logic [TICK_W-1:0] TIMEOUT_RST       = 8'd5;

    // Input word kinds (carried on tuser)
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // Result word
    typedef struct packed {
        logic calibrated;
        logic temp_led;
        logic light_led;
        logic touch_led;
    } result_t;

endpackage

// ===== src/sensor_baseline_hysteresis_ctrl_unit.sv =====
`timescale 1ns / 1ps
// Sensor baseline / hysteresis controller: averaging, baselines, LED hysteresis and timeout.
// Depends on sbhc_pkg.
//
//  Channel | Dir | Handshake          | Word
//  --------+-----+--------------------+------------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: light, touch, temp samples; tuser: action
//  m_*     | out | m_tvalid/m_tready  | tdata: touch_led, light_led, temp_led, calibrated
//  APB     | in  | psel/penable       | seven threshold/timeout registers, 4-byte stride
//
// One word per cycle sustained while m_tready is high; each word passes the input register, then the result register.
// Input register feeds one pass of logic (sum update, reciprocal multiply for the
// group average, threshold compares) that writes the state and the result register.
// Both stages advance together; a stalled result holds and the input register keeps
// accepting as long as it can move forward. All control and state clear on rst_n low.

module sensor_baseline_hysteresis_ctrl_unit
    import sbhc_pkg::*;
#(
    parameter int AVG_COUNT = AVG_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [9:0] light_sample, [19:10] touch_sample, [29:20] temp_sample
    input  logic        s_tuser,   // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] touch_led, [1] light_led, [2] temp_led, [3] calibrated
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Group counter width
    localparam int CNT_W = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;

    // Reciprocal for the exact floor(sum / AVG_COUNT)
    localparam int     DIV_L   = $clog2(AVG_COUNT);
    localparam int     DIV_S   = SUM_W + DIV_L;
    localparam int     PROD_W  = DIV_S + SUM_W;
    localparam longint DIV_M   = ((longint'(1) << DIV_S) + longint'(AVG_COUNT) - 1)
                                 / longint'(AVG_COUNT);
    localparam logic [SUM_W:0] DIV_MUL = DIV_M[SUM_W:0];
    localparam logic [CNT_W:0] GROUP_LEN = (CNT_W + 1)'(AVG_COUNT);

    // Configuration registers
    logic [PCT_W-1:0]  touch_release_reg;
    logic [PCT_W-1:0]  touch_press_reg;
    logic [PCT_W-1:0]  light_low_reg;
    logic [PCT_W-1:0]  light_high_reg;
    logic [PM_W-1:0]   temp_low_reg;
    logic [PM_W-1:0]   temp_high_reg;
    logic [TICK_W-1:0] timeout_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_release_reg <= TOUCH_RELEASE_RST;
            touch_press_reg   <= TOUCH_PRESS_RST;
            light_low_reg     <= LIGHT_LOW_RST;
            light_high_reg    <= LIGHT_HIGH_RST;
            temp_low_reg      <= TEMP_LOW_RST;
            temp_high_reg     <= TEMP_HIGH_RST;
            timeout_reg       <= TIMEOUT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_TOUCH_RELEASE: touch_release_reg <= pwdata[PCT_W-1:0];
                REG_TOUCH_PRESS:   touch_press_reg   <= pwdata[PCT_W-1:0];
                REG_LIGHT_LOW:     light_low_reg     <= pwdata[PCT_W-1:0];
                REG_LIGHT_HIGH:    light_high_reg    <= pwdata[PCT_W-1:0];
                REG_TEMP_LOW:      temp_low_reg      <= pwdata[PM_W-1:0];
                REG_TEMP_HIGH:     temp_high_reg     <= pwdata[PM_W-1:0];
                REG_TIMEOUT:       timeout_reg       <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (cfg_idx)
            REG_TOUCH_RELEASE: prdata = 32'(touch_release_reg);
            REG_TOUCH_PRESS:   prdata = 32'(touch_press_reg);
            REG_LIGHT_LOW:     prdata = 32'(light_low_reg);
            REG_LIGHT_HIGH:    prdata = 32'(light_high_reg);
            REG_TEMP_LOW:      prdata = 32'(temp_low_reg);
            REG_TEMP_HIGH:     prdata = 32'(temp_high_reg);
            REG_TIMEOUT:       prdata = 32'(timeout_reg);
            default:           prdata = 32'd0;
        endcase
    end

    // Handshake and stage control
    logic                in_valid_reg;
    logic                in_action_reg;
    logic [SAMPLE_W-1:0] in_light_reg;
    logic [SAMPLE_W-1:0] in_touch_reg;
    logic [SAMPLE_W-1:0] in_temp_reg;
    logic                out_valid_reg;
    result_t             out_data_reg;
    logic                advance;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_action_reg <= s_tuser;
            in_light_reg  <= s_tdata[SAMPLE_W-1:0];
            in_touch_reg  <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            in_temp_reg   <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
        end
    end

    // Block state
    logic [CNT_W-1:0]    group_count_reg, group_count_next;
    logic                baseline_done_reg, baseline_done_next;
    logic [SUM_W-1:0]    light_sum_reg, light_sum_next;
    logic [SUM_W-1:0]    touch_sum_reg, touch_sum_next;
    logic [SUM_W-1:0]    temp_sum_reg, temp_sum_next;
    logic [SAMPLE_W-1:0] room_light_reg, room_light_next;
    logic [SAMPLE_W-1:0] room_touch_reg, room_touch_next;
    logic [SUM_W-1:0]    room_temp_reg, room_temp_next;
    logic                armed_reg, armed_next;
    logic                touch_led_reg, touch_led_next;
    logic                light_led_reg, light_led_next;
    logic                temp_led_reg, temp_led_next;
    logic [TICK_W-1:0]   tick_count_reg, tick_count_next;
    logic                timer_en_reg, timer_en_next;

    // Sums including the current set
    logic [SUM_W-1:0] light_acc, touch_acc, temp_acc;
    logic             group_end;

    assign light_acc = light_sum_reg + SUM_W'(in_light_reg);
    assign touch_acc = touch_sum_reg + SUM_W'(in_touch_reg);
    assign temp_acc  = temp_sum_reg + SUM_W'(in_temp_reg);
    assign group_end = ({1'b0, group_count_reg} + 1'b1) >= GROUP_LEN;

    // Group averages by reciprocal multiply
    logic [PROD_W-1:0] light_prod, touch_prod;
    logic [SUM_W-1:0]  light_avg, touch_avg;

    assign light_prod = PROD_W'(light_acc) * PROD_W'(DIV_MUL);
    assign touch_prod = PROD_W'(touch_acc) * PROD_W'(DIV_MUL);
    assign light_avg  = light_prod[DIV_S +: SUM_W];
    assign touch_avg  = touch_prod[DIV_S +: SUM_W];

    // Scaled values and thresholds
    logic [PCT_CMP_W-1:0] touch_x, touch_rel_thr, touch_prs_thr;
    logic [PCT_CMP_W-1:0] light_x, light_lo_thr, light_hi_thr;
    logic [PM_CMP_W-1:0]  temp_x, temp_lo_thr, temp_hi_thr;

    assign touch_x       = PCT_CMP_W'(touch_avg) * PCT_CMP_W'(100);
    assign light_x       = PCT_CMP_W'(light_avg) * PCT_CMP_W'(100);
    assign touch_rel_thr = PCT_CMP_W'(room_touch_reg) * PCT_CMP_W'(touch_release_reg);
    assign touch_prs_thr = PCT_CMP_W'(room_touch_reg) * PCT_CMP_W'(touch_press_reg);
    assign light_lo_thr  = PCT_CMP_W'(room_light_reg) * PCT_CMP_W'(light_low_reg);
    assign light_hi_thr  = PCT_CMP_W'(room_light_reg) * PCT_CMP_W'(light_high_reg);
    assign temp_x        = PM_CMP_W'(temp_acc) * PM_CMP_W'(1000);
    assign temp_lo_thr   = PM_CMP_W'(room_temp_reg) * PM_CMP_W'(temp_low_reg);
    assign temp_hi_thr   = PM_CMP_W'(room_temp_reg) * PM_CMP_W'(temp_high_reg);

    // Next-state logic for one word
    logic [TICK_W-1:0] tick_inc;
    logic              armed_tmp, led_tmp;

    assign tick_inc = tick_count_reg + 1'b1;

    always_comb
    begin
        group_count_next   = group_count_reg;
        baseline_done_next = baseline_done_reg;
        light_sum_next     = light_sum_reg;
        touch_sum_next     = touch_sum_reg;
        temp_sum_next      = temp_sum_reg;
        room_light_next    = room_light_reg;
        room_touch_next    = room_touch_reg;
        room_temp_next     = room_temp_reg;
        armed_next         = armed_reg;
        touch_led_next     = touch_led_reg;
        light_led_next     = light_led_reg;
        temp_led_next      = temp_led_reg;
        tick_count_next    = tick_count_reg;
        timer_en_next      = timer_en_reg;
        armed_tmp          = armed_reg;
        led_tmp            = touch_led_reg;

        if (in_action_reg == ACT_SAMPLE)
        begin
            if (group_end)
            begin
                group_count_next = '0;
                light_sum_next   = '0;
                touch_sum_next   = '0;
                temp_sum_next    = '0;
                if (!baseline_done_reg)
                begin
                    // first group sets the room baselines
                    room_light_next    = light_avg[SAMPLE_W-1:0];
                    room_touch_next    = touch_avg[SAMPLE_W-1:0];
                    room_temp_next     = temp_acc;
                    baseline_done_next = 1'b1;
                end
                else
                begin
                    // touch: re-arm, then toggle on press
                    if (touch_x >= touch_rel_thr)
                    begin
                        armed_tmp = 1'b1;
                    end
                    if (touch_x <= touch_prs_thr && armed_tmp)
                    begin
                        led_tmp   = ~led_tmp;
                        armed_tmp = 1'b0;
                    end
                    armed_next     = armed_tmp;
                    touch_led_next = led_tmp;
                    if (armed_tmp && led_tmp)
                    begin
                        timer_en_next = 1'b1;
                    end
                    else
                    begin
                        timer_en_next   = 1'b0;
                        tick_count_next = '0;
                    end

                    // light: dead zone is the closed band
                    if (!(light_x >= light_lo_thr && light_x <= light_hi_thr))
                    begin
                        if (light_x >= light_hi_thr)
                        begin
                            light_led_next = 1'b1;
                        end
                        if (light_x <= light_lo_thr)
                        begin
                            light_led_next = 1'b0;
                        end
                    end

                    // temperature: dead zone is the open band
                    if (!(temp_x > temp_lo_thr && temp_x < temp_hi_thr))
                    begin
                        if (temp_x >= temp_hi_thr)
                        begin
                            temp_led_next = 1'b1;
                        end
                        if (temp_x <= temp_lo_thr)
                        begin
                            temp_led_next = 1'b0;
                        end
                    end
                end
            end
            else
            begin
                group_count_next = group_count_reg + 1'b1;
                light_sum_next   = light_acc;
                touch_sum_next   = touch_acc;
                temp_sum_next    = temp_acc;
            end
        end
        else if (timer_en_reg)
        begin
            // timeout on a lit, released touch LED
            if (tick_inc >= timeout_reg)
            begin
                touch_led_next  = 1'b0;
                tick_count_next = '0;
                timer_en_next   = 1'b0;
            end
            else
            begin
                tick_count_next = tick_inc;
            end
        end
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg   <= '0;
            baseline_done_reg <= 1'b0;
            light_sum_reg     <= '0;
            touch_sum_reg     <= '0;
            temp_sum_reg      <= '0;
            room_light_reg    <= '0;
            room_touch_reg    <= '0;
            room_temp_reg     <= '0;
            armed_reg         <= 1'b0;
            touch_led_reg     <= 1'b0;
            light_led_reg     <= 1'b0;
            temp_led_reg      <= 1'b0;
            tick_count_reg    <= '0;
            timer_en_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                group_count_reg   <= group_count_next;
                baseline_done_reg <= baseline_done_next;
                light_sum_reg     <= light_sum_next;
                touch_sum_reg     <= touch_sum_next;
                temp_sum_reg      <= temp_sum_next;
                room_light_reg    <= room_light_next;
                room_touch_reg    <= room_touch_next;
                room_temp_reg     <= room_temp_next;
                armed_reg         <= armed_next;
                touch_led_reg     <= touch_led_next;
                light_led_reg     <= light_led_next;
                temp_led_reg      <= temp_led_next;
                tick_count_reg    <= tick_count_next;
                timer_en_reg      <= timer_en_next;
                out_valid_reg     <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.touch_led  <= touch_led_next;
            out_data_reg.light_led  <= light_led_next;
            out_data_reg.temp_led   <= temp_led_next;
            out_data_reg.calibrated <= baseline_done_next;
        end
    end

endmodule
